### hdl/pixel_intensity_stretch_macros.svh
// Assertion macros for the intensity stretch block.
`ifndef PIXEL_INTENSITY_STRETCH_MACROS_SVH
`define PIXEL_INTENSITY_STRETCH_MACROS_SVH

// same-cycle implication
`define PIS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pixel_intensity_stretch: same-cycle check failed");

// next-cycle implication
`define PIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pixel_intensity_stretch: next-cycle check failed");

`endif

### hdl/pis_pkg.sv
package pis_pkg;

	localparam int PIX_W      = 16;
	localparam int DIFF_W     = PIX_W + 1;
	localparam int MAG_W      = PIX_W;
	localparam int REM_W      = MAG_W + 1;
	localparam int NUM_COLORS = 256;
	localparam int TOP        = NUM_COLORS - 1;
	localparam int IDX_W      = 8;
	localparam int QW         = MAG_W + $clog2(NUM_COLORS);
	localparam int CFG_IDX_W  = 2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_LOW  = 2'd0;
	localparam cfg_idx_t REG_HIGH = 2'd1;
	localparam cfg_idx_t REG_WRAP = 2'd2;

	typedef logic [2:0] sel_t;

	localparam sel_t SEL_ZERO = 3'd0;
	localparam sel_t SEL_TOP  = 3'd1;
	localparam sel_t SEL_RAMP = 3'd2;
	localparam sel_t SEL_INV  = 3'd3;
	localparam sel_t SEL_WRAP = 3'd4;

	// how the quotient turns into a color index
	typedef struct packed {
		sel_t sel;
		logic neg;
	} side_t;

endpackage

### hdl/pis_divider.sv
module pis_divider
	import pis_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  logic [QW-1:0]     up_num,
	input  logic [MAG_W-1:0]  up_den,
	input  side_t             up_side,
	output logic              dn_valid,
	input  logic              dn_ready,
	output logic [QW-1:0]     dn_quo,
	output side_t             dn_side
);

	// one quotient bit per stage, MSB first
	logic              vld_q  [QW];
	logic [QW-1:0]     num_q  [QW];
	logic [QW-1:0]     quo_q  [QW];
	logic [MAG_W-1:0]  rem_q  [QW];
	logic [MAG_W-1:0]  den_q  [QW];
	side_t             side_q [QW];

	logic              pre_vld  [QW];
	logic [QW-1:0]     pre_num  [QW];
	logic [QW-1:0]     pre_quo  [QW];
	logic [MAG_W-1:0]  pre_rem  [QW];
	logic [MAG_W-1:0]  pre_den  [QW];
	side_t             pre_side [QW];

	logic en [QW+1];

	assign en[QW]   = dn_ready;
	assign up_ready = en[0];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [REM_W-1:0] trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign pre_vld[k]  = up_valid;
			assign pre_num[k]  = up_num;
			assign pre_quo[k]  = '0;
			assign pre_rem[k]  = '0;
			assign pre_den[k]  = up_den;
			assign pre_side[k] = up_side;
		end else begin : g_next
			assign pre_vld[k]  = vld_q[k-1];
			assign pre_num[k]  = num_q[k-1];
			assign pre_quo[k]  = quo_q[k-1];
			assign pre_rem[k]  = rem_q[k-1];
			assign pre_den[k]  = den_q[k-1];
			assign pre_side[k] = side_q[k-1];
		end

		assign en[k] = !vld_q[k] || en[k+1];
		assign trial = {pre_rem[k], pre_num[k][QW-1]};
		assign ge    = trial >= REM_W'(pre_den[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en[k]) begin
				vld_q[k] <= pre_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && pre_vld[k]) begin
				num_q[k]  <= {pre_num[k][QW-2:0], 1'b0};
				quo_q[k]  <= {pre_quo[k][QW-2:0], ge};
				rem_q[k]  <= ge ? MAG_W'(trial - REM_W'(pre_den[k])) : MAG_W'(trial);
				den_q[k]  <= pre_den[k];
				side_q[k] <= pre_side[k];
			end
		end
	end

	assign dn_valid = vld_q[QW-1];
	assign dn_quo   = quo_q[QW-1];
	assign dn_side  = side_q[QW-1];

endmodule

### hdl/pixel_intensity_stretch.sv
// Stages from input acceptance to output valid: operand stage,
// multiply stage, 24 divider stages, output register.
// Throughput: one item per cycle unless out_ready stalls the output; the restoring divider is fully pipelined.
// Reset (arst_n low) clears all valid bits and sets low_level to 0,
// high_level to 255 and wrap_enable to 0.
`include "pixel_intensity_stretch_macros.svh"

module pixel_intensity_stretch
	import pis_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [PIX_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [PIX_W-1:0]  pixel_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [IDX_W-1:0]         color_index
);

	logic signed [PIX_W-1:0] low_q;
	logic signed [PIX_W-1:0] high_q;
	logic                    wrap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= PIX_W'(255);
			wrap_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LOW:  low_q  <= cfg_data;
				REG_HIGH: high_q <= cfg_data;
				REG_WRAP: wrap_q <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	// stage 1: offset, span and region
	logic                    rising;
	logic signed [PIX_W-1:0] origin;
	logic [DIFF_W-1:0]       diff;
	logic [DIFF_W-1:0]       span_d;
	logic [MAG_W-1:0]        span_mag;
	logic [MAG_W-1:0]        span_fix;
	side_t                   side_in;

	assign rising   = high_q > low_q;
	assign origin   = (wrap_q || rising) ? low_q : high_q;
	assign diff     = {pixel_value[PIX_W-1], pixel_value} - {origin[PIX_W-1], origin};
	assign span_d   = {high_q[PIX_W-1], high_q} - {low_q[PIX_W-1], low_q};
	assign span_mag = span_d[DIFF_W-1] ? MAG_W'(~span_d + DIFF_W'(1)) : MAG_W'(span_d);
	assign span_fix = (span_mag == '0) ? MAG_W'(1) : span_mag;

	always_comb begin
		side_in.neg = diff[DIFF_W-1];
		if (wrap_q) begin
			side_in.sel = SEL_WRAP;
		end else if (rising) begin
			if (pixel_value < low_q)
				side_in.sel = SEL_ZERO;
			else if (pixel_value <= high_q)
				side_in.sel = SEL_RAMP;
			else
				side_in.sel = SEL_TOP;
		end else begin
			if (pixel_value < high_q)
				side_in.sel = SEL_TOP;
			else if (pixel_value <= low_q)
				side_in.sel = SEL_INV;
			else
				side_in.sel = SEL_ZERO;
		end
	end

	logic             valid_s1;
	logic [MAG_W-1:0] mag_s1;
	logic [MAG_W-1:0] span_s1;
	side_t            side_s1;
	logic             valid_s2;
	logic [QW-1:0]    num_s2;
	logic [MAG_W-1:0] span_s2;
	side_t            side_s2;
	logic             en_s1;
	logic             en_s2;
	logic             div_ready;
	logic             div_valid;
	logic [QW-1:0]    div_quo;
	side_t            div_side;
	logic             en_out;

	assign en_out   = !out_valid || out_ready;
	assign en_s2    = !valid_s2 || div_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1)
				valid_s1 <= in_valid;
			if (en_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			mag_s1  <= diff[DIFF_W-1] ? MAG_W'(~diff + DIFF_W'(1)) : MAG_W'(diff);
			span_s1 <= span_fix;
			side_s1 <= side_in;
		end
		// stage 2: scale by the top color
		if (en_s2 && valid_s1) begin
			num_s2  <= QW'(mag_s1) * QW'(TOP);
			span_s2 <= span_s1;
			side_s2 <= side_s1;
		end
	end

	pis_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_s2),
		.up_ready (div_ready),
		.up_num   (num_s2),
		.up_den   (span_s2),
		.up_side  (side_s2),
		.dn_valid (div_valid),
		.dn_ready (en_out),
		.dn_quo   (div_quo),
		.dn_side  (div_side)
	);

	logic [IDX_W-1:0] q8;
	logic [IDX_W-1:0] res;
	logic             out_valid_q;
	logic [IDX_W-1:0] color_index_q;

	assign q8 = div_quo[IDX_W-1:0];

	always_comb begin
		case (div_side.sel)
			SEL_ZERO: res = '0;
			SEL_TOP:  res = IDX_W'(TOP);
			SEL_RAMP: res = q8;
			SEL_INV:  res = IDX_W'(TOP) - q8;
			SEL_WRAP: res = div_side.neg ? ({IDX_W{1'b0}} - q8) : q8;
			default:  res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && div_valid)
			color_index_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign color_index = color_index_q;

	`PIS_ASSERT_NOW(a_ramp_in_range, clk, arst_n, div_valid && (div_side.sel == SEL_RAMP || div_side.sel == SEL_INV), div_quo <= QW'(TOP))
	`PIS_ASSERT_NEXT(a_accept_enters, clk, arst_n, in_valid && in_ready, valid_s1)
	`PIS_ASSERT_NEXT(a_s2_holds, clk, arst_n, valid_s2 && !div_ready, valid_s2 && $stable(num_s2))

endmodule

### bench/pixel_intensity_stretch_test.sv
`timescale 1ns / 100ps

module pixel_intensity_stretch_test;
	import pis_pkg::*;

	localparam cfg_idx_t REG_NONE = 2'd3;
	localparam int LATENCY = 27;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD = 300;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [PIX_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [PIX_W-1:0] pixel_value;
	logic                    out_valid;
	logic                    out_ready;
	logic [IDX_W-1:0]        color_index;

	// shadow copy of the block's registers
	logic signed [PIX_W-1:0] level_low;
	logic signed [PIX_W-1:0] level_high;
	logic                    wrap_on;

	logic [IDX_W-1:0] colors_due[$];

	int errors;
	int pixels_sent;
	int settings_used;
	int burst_left;
	int hold_cycles;
	bit no_idle;
	int idle_cycles;

	pixel_intensity_stretch dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel_value(pixel_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.color_index(color_index)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [IDX_W-1:0] stretch_color(logic signed [PIX_W-1:0] v);
		longint lo, hi, x, span, t, r;
		lo = longint'(level_low);
		hi = longint'(level_high);
		x = longint'(v);
		span = hi - lo;
		if (span < 0)
			span = -span;
		if (span == 0)
			span = 1;
		if (wrap_on) begin
			t = (x - lo) * TOP / span;
			r = t % NUM_COLORS;
			if (r < 0)
				r += NUM_COLORS;
		end else if (hi > lo) begin
			if (x < lo)
				r = 0;
			else if (x <= hi)
				r = (x - lo) * TOP / span;
			else
				r = TOP;
		end else begin
			if (x < hi)
				r = TOP;
			else if (x <= lo)
				r = TOP - (x - hi) * TOP / span;
			else
				r = 0;
		end
		return r[IDX_W-1:0];
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_pixel(input logic signed [PIX_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0 || no_idle) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid = 1'b1;
		pixel_value = v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		colors_due.push_back(stretch_color(v));
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid = 1'b0;
		while (colors_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [PIX_W-1:0] data);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cfg_index = CFG_IDX_W'($urandom);
		cfg_data = PIX_W'($urandom);
		case (idx)
			REG_LOW: level_low = data;
			REG_HIGH: level_high = data;
			REG_WRAP: wrap_on = data[0];
			default: ;
		endcase
	endtask

	task automatic set_levels(input int lo, input int hi, input bit wrap);
		drain();
		write_reg(REG_LOW, lo[PIX_W-1:0]);
		write_reg(REG_HIGH, hi[PIX_W-1:0]);
		write_reg(REG_WRAP, {(PIX_W-1)'($urandom_range(0, 32767)), wrap});
		settings_used++;
	endtask

	task automatic test_reset_levels;
		send_pixel(-16'sd32768);
		send_pixel(-16'sd1);
		send_pixel(16'sd0);
		send_pixel(16'sd1);
		send_pixel(16'sd128);
		send_pixel(16'sd254);
		send_pixel(16'sd255);
		send_pixel(16'sd256);
		send_pixel(16'sd32767);
	endtask

	task automatic test_edge_levels;
		// widest rising ramp
		set_levels(-32768, 32767, 1'b0);
		send_pixel(-16'sd32768);
		send_pixel(16'sd0);
		send_pixel(16'sd32767);
		// widest falling ramp
		set_levels(32767, -32768, 1'b0);
		send_pixel(-16'sd32768);
		send_pixel(16'sd0);
		send_pixel(16'sd32767);
		// equal levels: span repaired to one
		set_levels(100, 100, 1'b0);
		send_pixel(16'sd99);
		send_pixel(16'sd100);
		send_pixel(16'sd101);
		// wrap with a tiny span, large positive and negative ramp values
		set_levels(0, 1, 1'b1);
		send_pixel(16'sd32767);
		send_pixel(-16'sd32768);
		send_pixel(-16'sd1);
		send_pixel(16'sd3);
		// write to an unused index is ignored
		drain();
		write_reg(REG_NONE, 16'hffff);
		send_pixel(16'sd5);
	endtask

	task automatic pick_levels;
		int lo, hi;
		lo = int'($signed(16'($urandom)));
		case ($urandom_range(0, 5))
			0: hi = int'($signed(16'($urandom)));
			1: hi = lo + $urandom_range(0, 40) - 20;
			2: begin
				lo = $urandom_range(0, 1) ? -32768 : 32767;
				hi = -1 - lo;
			end
			3: hi = lo;
			4: hi = lo + $urandom_range(0, 2000) - 1000;
			default: hi = lo + $urandom_range(0, 300);
		endcase
		if (hi > 32767)
			hi = 32767;
		if (hi < -32768)
			hi = -32768;
		set_levels(lo, hi, $urandom_range(0, 1));
	endtask

	task automatic send_random_pixels(input int count);
		int lo, hi, v;
		lo = int'(level_low);
		hi = int'(level_high);
		repeat (count) begin
			case ($urandom_range(0, 5))
				0, 1: v = $urandom;
				2: v = lo + $urandom_range(0, 20) - 10;
				3: v = hi + $urandom_range(0, 20) - 10;
				4: v = (lo < hi ? lo : hi) + $urandom_range(0, hi > lo ? hi - lo : lo - hi);
				default: v = $urandom_range(0, 1) ? -32768 : 32767;
			endcase
			send_pixel(v[PIX_W-1:0]);
		end
	endtask

	task automatic test_random_levels;
		repeat (12) begin
			pick_levels();
			send_random_pixels(95);
		end
	endtask

	task automatic test_output_stall;
		pick_levels();
		hold_cycles = LONG_HOLD;
		send_random_pixels(100);
	endtask

	task automatic test_full_rate;
		pick_levels();
		no_idle = 1'b1;
		burst_left = 0;
		send_random_pixels(100);
		drain();
		no_idle = 1'b0;
	endtask

	// receiver: random stalls, always ready in full-rate mode, or a long hold when one is requested
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready = 1'b0;
				hold_cycles--;
			end else if (no_idle)
				out_ready = 1'b1;
			else
				out_ready = ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (colors_due.size() == 0) begin
				$display("%0t: unexpected item, expected none, got color_index %0d",
					$time, color_index);
				errors++;
			end else begin
				if (color_index !== colors_due[0]) begin
					$display("%0t: color_index mismatch, expected %0d, got %0d",
						$time, colors_due[0], color_index);
					errors++;
				end
				void'(colors_due.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("pixel_intensity_stretch_test: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_value = '0;
		level_low = 16'sd0;
		level_high = 16'sd255;
		wrap_on = 1'b0;
		errors = 0;
		pixels_sent = 0;
		settings_used = 1;
		burst_left = 0;
		hold_cycles = 0;
		no_idle = 1'b0;
		idle_cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_levels();
		test_edge_levels();
		test_random_levels();
		test_output_stall();
		test_full_rate();

		drain();
		repeat (LATENCY + 13) @(posedge clk);
		$display("%0d pixels mapped under %0d level settings, clamp and wrap,",
			pixels_sent, settings_used);
		$display("with bursty input, random output stalls and one long hold; %0d errors",
			errors);
		if (errors == 0)
			$display("pixel_intensity_stretch_test: PASS");
		else
			$display("pixel_intensity_stretch_test: FAIL");
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/pis_pkg.sv
hdl/pis_divider.sv
hdl/pixel_intensity_stretch.sv
bench/pixel_intensity_stretch_test.sv
